/* design/msrc_pkg.sv */
// Package: shared constants, types and the CRC-16 byte update for the reply checker.
`timescale 1ns / 1ps
package msrc_pkg;

  localparam int MAX_DATA_BYTES_DEF = 4;

  // Configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_LENGTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_MODE = 1'd1;
  localparam logic [2:0] DATA_LENGTH_RST = 3'd4;

  // Content modes
  localparam logic [1:0] MODE_HUM_TEMP = 2'd0;
  localparam logic [1:0] MODE_TEMP     = 2'd1;
  localparam logic [1:0] MODE_HUM      = 2'd2;
  localparam logic [1:0] MODE_RAW      = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_CMD = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;
  localparam logic [1:0] ST_BAD_CRC = 2'd3;

  localparam logic [7:0]  READ_CMD    = 8'h03;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] RAW_INVALID = 16'hFFFF;
  localparam logic [15:0] SIGN_BIT    = 16'h8000;
  localparam logic [15:0] MAG_MASK    = 16'h7FFF;

  // Data bytes kept in the data word
  localparam int STORE_BYTES = 4;

  // Frame queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Completed frame, front to back
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_word;
    logic [2:0]  stored;     // data bytes held in data_word, 1..4
    logic [1:0]  mode;
  } msrc_frame_t;

  // Reflected CRC-16, one byte folded in
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

/* design/modbus_sensor_reply_checker.sv */
// Top level: register-read reply checker with CRC-16 and sensor value conversion.
//
//   channel | signals                                   | transfer when
//   --------+-------------------------------------------+------------------------
//   in      | in_rx_byte, in_frame_start                | in_valid && in_ready
//   out     | out_status, out_data_word, out_humidity_*,| out_valid && out_ready
//           | out_temperature_*                         |
//   cfg     | cfg_index, cfg_wdata                      | cfg_we
//
// One reply byte per cycle while in_ready is high; the CRC update is an unrolled 8-bit
// step in the front. After its final byte, the front summary goes into the queue,
// then the conversion goes into the output register. Reset is synchronous and clears
// the frame state, the queue and the result valid. When out_ready is low the
// output register holds and the two-entry queue absorbs further frames; in_ready
// drops only when the queue is full.
`timescale 1ns / 1ps
module modbus_sensor_reply_checker
  import msrc_pkg::*;
#(
  parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  input  logic                  in_frame_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [31:0]           out_data_word,
  output logic [15:0]           out_humidity_tenths,
  output logic                  out_humidity_valid,
  output logic signed [15:0]    out_temperature_tenths,
  output logic                  out_temperature_valid,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [2:0]  data_length_r;
  logic [1:0]  content_mode_r;
  logic        q_push, q_pop, q_full, q_empty;
  msrc_frame_t q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_length_r  <= DATA_LENGTH_RST;
      content_mode_r <= MODE_HUM_TEMP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DATA_LENGTH:  data_length_r  <= cfg_wdata;
        CFG_CONTENT_MODE: content_mode_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  msrc_front #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (in_rx_byte),
    .frame_start  (in_frame_start),
    .data_length  (data_length_r),
    .content_mode (content_mode_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_frame      (q_in)
  );

  msrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_frame (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  msrc_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_empty                (q_empty),
    .q_head                 (q_head),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_data_word          (out_data_word),
    .out_humidity_tenths    (out_humidity_tenths),
    .out_humidity_valid     (out_humidity_valid),
    .out_temperature_tenths (out_temperature_tenths),
    .out_temperature_valid  (out_temperature_valid)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("frame queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("frame queue underflow");

  a_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_data_word == 32'h0 && !out_humidity_valid && !out_temperature_valid))
    else $error("failed frame carries data");

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid)
    else $error("popped frame not presented");

endmodule

/* design/msrc_front.sv */
// Front end: frame position tracking, header checks, CRC accumulation, frame summary.
`timescale 1ns / 1ps
module msrc_front
  import msrc_pkg::*;
#(
  parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  input  logic [2:0]  data_length,
  input  logic [1:0]  content_mode,
  input  logic        q_full,
  output logic        q_push,
  output msrc_frame_t q_frame
);

  localparam int CNT_W = $clog2(MAX_DATA_BYTES + 4);

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [31:0]      data_shift_r, data_shift_nxt;
  logic [1:0]       header_error_r, header_error_nxt;
  logic [7:0]       crc_low_r, crc_low_nxt;

  logic [CNT_W-1:0] len, cnt;
  logic [15:0]      crc_cur;
  logic [31:0]      ds_cur;
  logic [1:0]       herr_cur;
  logic [7:0]       crc_low_cur;
  logic             accept, last;

  always_comb begin
    len = CNT_W'(data_length);
    if (len == '0) len = CNT_W'(1);
    else if (len > CNT_W'(MAX_DATA_BYTES)) len = CNT_W'(MAX_DATA_BYTES);
  end

  // frame_start drops any partial frame
  assign cnt         = frame_start ? '0 : byte_count_r;
  assign crc_cur     = frame_start ? CRC_INIT : crc_r;
  assign ds_cur      = frame_start ? '0 : data_shift_r;
  assign herr_cur    = frame_start ? ST_OK : header_error_r;
  assign crc_low_cur = frame_start ? 8'h00 : crc_low_r;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign last     = (cnt >= len + CNT_W'(3));
  assign q_push   = accept && last;

  always_comb begin
    q_frame.data_word = ds_cur;
    q_frame.mode      = content_mode;
    q_frame.stored    = (len < CNT_W'(STORE_BYTES)) ? 3'(len) : 3'(STORE_BYTES);
    if (herr_cur != ST_OK)                       q_frame.status = herr_cur;
    else if (crc_cur != {rx_byte, crc_low_cur})  q_frame.status = ST_BAD_CRC;
    else                                         q_frame.status = ST_OK;
  end

  always_comb begin
    byte_count_nxt   = byte_count_r;
    crc_nxt          = crc_r;
    data_shift_nxt   = data_shift_r;
    header_error_nxt = header_error_r;
    crc_low_nxt      = crc_low_r;
    if (accept) begin
      if (last) begin
        byte_count_nxt   = '0;
        crc_nxt          = CRC_INIT;
        data_shift_nxt   = '0;
        header_error_nxt = ST_OK;
        crc_low_nxt      = 8'h00;
      end else begin
        byte_count_nxt   = cnt + CNT_W'(1);
        crc_nxt          = crc_cur;
        data_shift_nxt   = ds_cur;
        header_error_nxt = herr_cur;
        crc_low_nxt      = crc_low_cur;
        if (cnt == CNT_W'(0)) begin
          if (rx_byte != READ_CMD) header_error_nxt = ST_BAD_CMD;
        end else if (cnt == CNT_W'(1)) begin
          if (herr_cur == ST_OK && rx_byte != 8'(len)) header_error_nxt = ST_BAD_LEN;
        end else if (cnt < len + CNT_W'(2)) begin
          if (cnt < CNT_W'(STORE_BYTES + 2)) data_shift_nxt = {ds_cur[23:0], rx_byte};
        end else begin
          crc_low_nxt = rx_byte;
        end
        if (cnt < len + CNT_W'(2)) crc_nxt = crc16_fold(crc_cur, rx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      crc_r          <= CRC_INIT;
      data_shift_r   <= '0;
      header_error_r <= ST_OK;
      crc_low_r      <= 8'h00;
    end else begin
      byte_count_r   <= byte_count_nxt;
      crc_r          <= crc_nxt;
      data_shift_r   <= data_shift_nxt;
      header_error_r <= header_error_nxt;
      crc_low_r      <= crc_low_nxt;
    end
  end

endmodule

/* design/msrc_queue.sv */
// Short FIFO of completed frame summaries between front and back.
`timescale 1ns / 1ps
module msrc_queue
  import msrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  msrc_frame_t push_frame,
  input  logic        pop,
  output logic        full,
  output logic        empty,
  output msrc_frame_t head
);

  msrc_frame_t       entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) return '0;
    return p + QPTR_W'(1);
  endfunction

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)      count_nxt = count_r + QCNT_W'(1);
    else if (pop && !push) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* design/msrc_back.sv */
// Back end: value conversion of a completed frame into the registered result.
`timescale 1ns / 1ps
module msrc_back
  import msrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  msrc_frame_t        q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [31:0]        out_data_word,
  output logic [15:0]        out_humidity_tenths,
  output logic               out_humidity_valid,
  output logic signed [15:0] out_temperature_tenths,
  output logic               out_temperature_valid
);

  logic        valid_r;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] data_word_r, data_word_nxt;
  logic [15:0] hum_r, hum_nxt;
  logic        hum_ok_r, hum_ok_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic        temp_ok_r, temp_ok_nxt;

  logic [31:0] buf_word;
  logic [15:0] hum_raw, temp_raw;
  logic        hum_sel, temp_sel;

  assign q_pop = !q_empty && (!valid_r || out_ready);

  // Missing data bytes read as 0xFF
  always_comb begin
    case (q_head.stored)
      3'd1:    buf_word = {q_head.data_word[7:0], 24'hFFFFFF};
      3'd2:    buf_word = {q_head.data_word[15:0], 16'hFFFF};
      3'd3:    buf_word = {q_head.data_word[23:0], 8'hFF};
      default: buf_word = q_head.data_word;
    endcase
  end

  always_comb begin
    hum_raw  = buf_word[31:16];
    hum_sel  = 1'b0;
    temp_raw = buf_word[31:16];
    temp_sel = 1'b0;
    case (q_head.mode)
      MODE_HUM_TEMP: begin
        hum_sel  = 1'b1;
        temp_sel = 1'b1;
        temp_raw = buf_word[15:0];
      end
      MODE_TEMP: temp_sel = 1'b1;
      MODE_HUM:  hum_sel  = 1'b1;
      default: begin
        hum_sel  = 1'b0;
        temp_sel = 1'b0;
      end
    endcase
  end

  always_comb begin
    status_nxt    = q_head.status;
    data_word_nxt = '0;
    hum_nxt       = '0;
    hum_ok_nxt    = 1'b0;
    temp_nxt      = '0;
    temp_ok_nxt   = 1'b0;
    if (q_head.status == ST_OK) begin
      data_word_nxt = q_head.data_word;
      if (hum_sel && hum_raw != RAW_INVALID) begin
        hum_nxt    = hum_raw;
        hum_ok_nxt = 1'b1;
      end
      if (temp_sel && temp_raw != RAW_INVALID) begin
        temp_ok_nxt = 1'b1;
        // sign-magnitude to two's complement
        if ((temp_raw & SIGN_BIT) != 16'h0000) temp_nxt = 16'h0000 - (temp_raw & MAG_MASK);
        else                                   temp_nxt = temp_raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (q_pop) valid_r <= 1'b1;
    else if (out_ready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r    <= status_nxt;
      data_word_r <= data_word_nxt;
      hum_r       <= hum_nxt;
      hum_ok_r    <= hum_ok_nxt;
      temp_r      <= temp_nxt;
      temp_ok_r   <= temp_ok_nxt;
    end
  end

  assign out_valid              = valid_r;
  assign out_status             = status_r;
  assign out_data_word          = data_word_r;
  assign out_humidity_tenths    = hum_r;
  assign out_humidity_valid     = hum_ok_r;
  assign out_temperature_tenths = signed'(temp_r);
  assign out_temperature_valid  = temp_ok_r;

endmodule
